/* sv/wcc_pkg.sv */
`timescale 1ns / 1ps
// shared types, symbol codes and the line hash for the word cache compressor
// no dependencies; imported by the line store, encoder, top level and testbench
package wcc_pkg;

    localparam int MAX_LINES  = 16;
    localparam int WAYS       = 4;
    localparam int SEED_COUNT = 17;

    typedef logic [31:0]           t_word;
    typedef logic [WAYS-1:0][31:0] t_line;

    localparam t_word NEAR_MASK  = 32'hFFFF_F807;
    localparam t_word PAIR_MASK  = 32'h000F_0078;
    localparam t_word PAIR_TAG   = 32'h0000_0003;
    localparam t_word BYTE_HIGH  = 32'h0000_007F;
    localparam t_word BYTE_LOW   = 32'hFFFF_FF80;
    localparam t_word HALF_HIGH  = 32'h0000_FFFF;
    localparam t_word WORD_FALSE = 32'h0000_0002;
    localparam t_word WORD_NIL   = 32'h0000_0006;

    localparam logic [7:0] SYM_BLANK     = 8'd0;
    localparam logic [7:0] SYM_OFF       = 8'd1;
    localparam logic [7:0] SYM_NIL       = 8'd2;
    localparam logic [7:0] SYM_VICTIM0   = 8'd3;
    localparam logic [7:0] SYM_VICTIM1   = 8'd4;
    localparam logic [7:0] SYM_NEAR_V0   = 8'd5;
    localparam logic [7:0] SYM_NEAR_V1   = 8'd6;
    localparam logic [7:0] SYM_NEW32     = 8'd7;
    localparam logic [7:0] SYM_NEW16     = 8'd8;
    localparam logic [7:0] SYM_NEW4X2    = 8'd9;
    localparam logic [7:0] SYM_NEW8      = 8'd10;
    localparam logic [7:0] SYM_NEAR_BASE = 8'd32;

    localparam t_word SEED_WORDS [SEED_COUNT] = '{
        32'd10, 32'd9, 32'd8, 32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1,
        32'h0100_0003, 32'h0100_0002, 32'h0100_0001, 32'h0100_0000,
        32'h0001_0007, 32'h0001_000B, 32'h7676_6767
    };

    typedef struct packed {
        logic [MAX_LINES-1:0][WAYS-1:0][31:0] ways;
        t_word                                v0;
        t_word                                v1;
    } t_prefill;

    typedef struct packed {
        logic       valid;
        t_line      ways;
    } t_line_rd;

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] short_count;
        logic [7:0] short_first;
        logic [7:0] short_second;
        logic       has_long;
        t_word      long_word;
        logic       fixed;
        logic       wr_en;
        t_line      new_line;
        t_word      new_v0;
        t_word      new_v1;
    } t_enc;

    function automatic logic [3:0] line_of(input t_word w, input logic [4:0] num_lines);
        t_word      s;
        logic [4:0] m;
        s = (w >> 16) + (w >> 12) + {30'd0, w[1:0]};
        m = num_lines - 5'd1;
        return s[3:0] & m[3:0];
    endfunction

    function automatic t_prefill prefill_state(input logic [4:0] num_lines);
        t_prefill   p;
        logic [3:0] h;
        p = '0;
        for (int i = 0; i < SEED_COUNT; i++) begin
            h = line_of(SEED_WORDS[i], num_lines);
            if (p.ways[h][3] != '0) begin
                p.v1 = p.v0;
                p.v0 = p.ways[h][3];
            end
            p.ways[h] = {p.ways[h][2:0], SEED_WORDS[i]};
        end
        return p;
    endfunction

endpackage

/* sv/wcc_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for the input words and the coded results
// no dependencies
interface wcc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic        restart;

    modport source (output valid, output data_word, output restart, input ready);
    modport sink   (input valid, input data_word, input restart, output ready);
endinterface

interface wcc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  symbol;
    logic [1:0]  short_count;
    logic [7:0]  short_first;
    logic [7:0]  short_second;
    logic        has_long;
    logic [31:0] long_word;

    modport source (output valid, output symbol, output short_count, output short_first,
                    output short_second, output has_long, output long_word, input ready);
    modport sink   (input valid, input symbol, input short_count, input short_first,
                    input short_second, input has_long, input long_word, output ready);
endinterface

/* sv/wcc_line_mem.sv */
`timescale 1ns / 1ps
// line store: one line of four ways per entry, registered read, per-line valid bits
// depends on wcc_pkg
module wcc_line_mem #(
    parameter int NUM_LINES = 16,
    parameter int LINE_W    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [LINE_W-1:0] i_rd_addr,
    output wcc_pkg::t_line_rd o_rd,
    input  logic              i_wr_en,
    input  logic [LINE_W-1:0] i_wr_addr,
    input  wcc_pkg::t_line    i_wr_data,
    input  logic              i_clear
);
    import wcc_pkg::*;

    t_line                r_mem [NUM_LINES];
    t_line                r_q;
    t_line                r_fwd_data;
    logic                 r_fwd;
    logic                 r_rd_valid;
    logic [NUM_LINES-1:0] r_valid_bits;
    logic [NUM_LINES-1:0] n_valid_bits;

    always_comb begin
        n_valid_bits = i_clear ? '0 : r_valid_bits;
        if (i_wr_en) begin
            n_valid_bits[i_wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // write in the same cycle as the read wins over the stale array data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_fwd        <= 1'b0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_valid_bits <= n_valid_bits;
            if (i_rd_en) begin
                r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
                r_rd_valid <= n_valid_bits[i_rd_addr];
            end
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.ways  = r_fwd ? r_fwd_data : r_q;

endmodule

/* sv/wcc_encoder.sv */
`timescale 1ns / 1ps
// symbol selection and line / victim update for one word
// depends on wcc_pkg
module wcc_encoder #(
    parameter int NUM_LINES = 16
) (
    input  wcc_pkg::t_word  i_word,
    input  logic [3:0]      i_line,
    input  wcc_pkg::t_line  i_ways,
    input  wcc_pkg::t_word  i_v0,
    input  wcc_pkg::t_word  i_v1,
    output wcc_pkg::t_enc   o_enc
);
    import wcc_pkg::*;

    localparam logic [7:0] SYM_HIT_BASE = 8'(32 + NUM_LINES * 4);

    logic [3:0] hit;
    logic [3:0] near;
    logic [1:0] hit_way;
    logic [1:0] near_way;
    t_word      near_word;
    t_line      pushed;
    t_line      raised;

    always_comb begin
        near_word = i_word & NEAR_MASK;
        hit_way   = 2'd0;
        near_way  = 2'd0;
        for (int j = 0; j < 4; j++) begin
            hit[j]  = (i_ways[j] == i_word);
            near[j] = ((i_ways[j] & NEAR_MASK) == near_word);
        end
        for (int j = 3; j >= 0; j--) begin
            if (hit[j]) hit_way = 2'(j);
            if (near[j]) near_way = 2'(j);
        end
        pushed    = {i_ways[2:0], i_word};
        raised[0] = i_word;
        for (int j = 1; j < 4; j++) begin
            raised[j] = (2'(j) <= hit_way) ? i_ways[j-1] : i_ways[j];
        end
    end

    always_comb begin
        o_enc              = '0;
        o_enc.new_line     = pushed;
        o_enc.new_v0       = i_v0;
        o_enc.new_v1       = i_v1;
        if (i_word == '0) begin
            o_enc.symbol = SYM_BLANK;
            o_enc.fixed  = 1'b1;
        end else if (i_word == WORD_FALSE) begin
            o_enc.symbol = SYM_OFF;
            o_enc.fixed  = 1'b1;
        end else if (i_word == WORD_NIL) begin
            o_enc.symbol = SYM_NIL;
            o_enc.fixed  = 1'b1;
        end else if (hit != 4'd0) begin
            o_enc.symbol   = SYM_HIT_BASE + {2'b00, i_line, hit_way};
            o_enc.wr_en    = 1'b1;
            o_enc.new_line = raised;
        end else if (i_word == i_v0) begin
            o_enc.symbol = SYM_VICTIM0;
            o_enc.wr_en  = 1'b1;
            o_enc.new_v0 = i_ways[3];
        end else begin
            o_enc.wr_en  = 1'b1;
            o_enc.new_v0 = i_ways[3];
            o_enc.new_v1 = i_v0;
            if (i_word == i_v1) begin
                o_enc.symbol = SYM_VICTIM1;
            end else if (near != 4'd0) begin
                o_enc.symbol      = SYM_NEAR_BASE + {2'b00, i_line, near_way};
                o_enc.short_count = 2'd1;
                o_enc.short_first = i_word[10:3];
            end else if (near_word == (i_v0 & NEAR_MASK)) begin
                o_enc.symbol      = SYM_NEAR_V0;
                o_enc.short_count = 2'd1;
                o_enc.short_first = i_word[10:3];
            end else if (near_word == (i_v1 & NEAR_MASK)) begin
                o_enc.symbol      = SYM_NEAR_V1;
                o_enc.short_count = 2'd1;
                o_enc.short_first = i_word[10:3];
            end else if (i_word <= BYTE_HIGH || i_word >= BYTE_LOW) begin
                o_enc.symbol      = SYM_NEW8;
                o_enc.short_count = 2'd1;
                o_enc.short_first = i_word[7:0];
            end else if ((i_word & ~PAIR_MASK) == PAIR_TAG) begin
                o_enc.symbol      = SYM_NEW4X2;
                o_enc.short_count = 2'd1;
                o_enc.short_first = {i_word[19:16], i_word[6:3]};
            end else if (i_word <= HALF_HIGH) begin
                o_enc.symbol       = SYM_NEW16;
                o_enc.short_count  = 2'd2;
                o_enc.short_first  = i_word[15:8];
                o_enc.short_second = i_word[7:0];
            end else begin
                o_enc.symbol    = SYM_NEW32;
                o_enc.has_long  = 1'b1;
                o_enc.long_word = i_word;
            end
        end
    end

endmodule

/* sv/word_cache_compressor_unit.sv */
`timescale 1ns / 1ps
// top level of the word cache compressor: input stage, line store, encoder, output register
// depends on wcc_pkg, wcc_if, wcc_line_mem and wcc_encoder
//
// One word is taken every clock cycle unless the output stalls, and it is coded in stages:
// the first stage reads the word's line from the line store, the second compares the
// four ways and the two victims, writes the updated line back and loads the output
// register. A line written by the word just ahead is forwarded into the next read.
// A stall on the output holds both stages; the input stays ready whenever the output
// register is empty or being taken. Reset and a restart word reload the prefilled state
// at once through per-line valid bits (an unwritten line reads as its prefill value),
// so there is no clearing pass and the input never waits for one.
module word_cache_compressor_unit #(
    parameter int NUM_LINES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    wcc_in_if.sink           i_in,
    wcc_out_if.source        o_out
);
    import wcc_pkg::*;

    localparam int       LINE_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam t_prefill PREFILL = prefill_state(5'(NUM_LINES));

    logic              in_fire;
    logic              s1_adv;
    logic              s1_fire;
    logic [3:0]        in_line;
    logic              r_s1_valid;
    t_word             r_s1_word;
    logic              r_s1_restart;
    logic [LINE_W-1:0] r_s1_line;
    t_word             r_v0;
    t_word             r_v1;
    t_line_rd          rd;
    t_line             cur_ways;
    t_word             cur_v0;
    t_word             cur_v1;
    t_enc              enc;
    logic              r_out_valid;
    t_enc              r_out;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign s1_fire    = r_s1_valid && s1_adv;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_line    = line_of(i_in.data_word, 5'(NUM_LINES));

    wcc_line_mem #(
        .NUM_LINES (NUM_LINES),
        .LINE_W    (LINE_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_line[LINE_W-1:0]),
        .o_rd      (rd),
        .i_wr_en   (s1_fire && enc.wr_en),
        .i_wr_addr (r_s1_line),
        .i_wr_data (enc.new_line),
        .i_clear   (s1_fire && r_s1_restart)
    );

    always_comb begin
        if (r_s1_restart || !rd.valid) begin
            cur_ways = PREFILL.ways[4'(r_s1_line)];
        end else begin
            cur_ways = rd.ways;
        end
        cur_v0 = r_s1_restart ? PREFILL.v0 : r_v0;
        cur_v1 = r_s1_restart ? PREFILL.v1 : r_v1;
    end

    wcc_encoder #(
        .NUM_LINES (NUM_LINES)
    ) u_encoder (
        .i_word (r_s1_word),
        .i_line (4'(r_s1_line)),
        .i_ways (cur_ways),
        .i_v0   (cur_v0),
        .i_v1   (cur_v1),
        .o_enc  (enc)
    );

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_word    <= i_in.data_word;
            r_s1_restart <= i_in.restart;
            r_s1_line    <= in_line[LINE_W-1:0];
        end
        if (s1_fire) begin
            r_out <= enc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_v0        <= PREFILL.v0;
            r_v1        <= PREFILL.v1;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_fire) begin
                r_v0 <= enc.new_v0;
                r_v1 <= enc.new_v1;
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.symbol       = r_out.symbol;
    assign o_out.short_count  = r_out.short_count;
    assign o_out.short_first  = r_out.short_first;
    assign o_out.short_second = r_out.short_second;
    assign o_out.has_long     = r_out.has_long;
    assign o_out.long_word    = r_out.long_word;

`ifndef SYNTHESIS
    a_stall_holds_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !in_fire)
        else $error("line read issued while compare stage stalled");

    a_fixed_keeps_victims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && enc.fixed && !r_s1_restart) |=> (r_v0 == $past(r_v0) && r_v1 == $past(r_v1)))
        else $error("fixed word changed victim registers");

    a_long_only_new32: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_long) |-> (o_out.symbol == SYM_NEW32 && o_out.short_count == 2'd0))
        else $error("raw word emitted with wrong symbol");

    a_two_bytes_only_new16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.short_count == 2'd2) |-> (o_out.symbol == SYM_NEW16))
        else $error("two short bytes with wrong symbol");
`endif

endmodule

/* bench/word_cache_compressor_unit_tb.sv */
`timescale 1ns / 1ps
// testbench for word_cache_compressor_unit: directed rows, then random words over four idling phases
// every coded transaction is checked against a cache predictor kept in this file
// depends on wcc_pkg, wcc_if and the word_cache_compressor_unit rtl
module word_cache_compressor_unit_tb;
    import wcc_pkg::*;

    localparam int NUM_LINES      = 16;
    localparam int PHASE_WORDS    = 175;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HISTORY_DEPTH  = 64;
    localparam logic [7:0] HIT_BASE = SYM_NEAR_BASE + 8'(NUM_LINES * 4);

    typedef struct packed {
        logic [7:0] symbol;
        logic [1:0] short_count;
        logic [7:0] short_first;
        logic [7:0] short_second;
        logic       has_long;
        t_word      long_word;
    } t_code_out;

    typedef struct packed {
        t_word     word;
        t_code_out code;
    } t_pending;

    // typed = 1: the symbol is fixed and every other field is zero
    typedef struct packed {
        t_word      word;
        logic       restart;
        logic       typed;
        logic [7:0] symbol;
    } t_script_row;

    localparam int SCRIPT_LEN = 25;
    localparam t_script_row DIRECTED [SCRIPT_LEN] = '{
        '{32'h0000_0000, 1'b0, 1'b1, SYM_BLANK},
        '{32'h0000_0002, 1'b0, 1'b1, SYM_OFF},
        '{32'h0000_0006, 1'b0, 1'b1, SYM_NIL},
        '{32'h0000_000A, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0100_0001, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0000_07F8, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0000_007F, 1'b0, 1'b0, SYM_BLANK},
        '{32'hFFFF_FF80, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0000_1234, 1'b0, 1'b0, SYM_BLANK},
        '{32'h000A_0053, 1'b0, 1'b0, SYM_BLANK},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, SYM_BLANK},
        '{32'h8000_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0105_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0205_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0305_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0405_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0505_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0605_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0205_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0105_0000, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0105_07F8, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0505_07F8, 1'b0, 1'b0, SYM_BLANK},
        '{32'h0000_000A, 1'b1, 1'b0, SYM_BLANK},
        '{32'h0000_0000, 1'b1, 1'b1, SYM_BLANK},
        '{32'h0105_0000, 1'b0, 1'b0, SYM_BLANK}
    };

    logic i_clk;
    logic i_rst_n;

    wcc_in_if  word_ch ();
    wcc_out_if code_ch ();

    word_cache_compressor_unit #(
        .NUM_LINES (NUM_LINES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (code_ch)
    );

    t_line    cache_ways [NUM_LINES];
    t_word    vict0;
    t_word    vict1;
    t_pending pending_codes [$];
    t_word    recent_words [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stuck_cycles   = 0;
    int n_errors   = 0;
    int n_words    = 0;
    int n_restarts = 0;
    int n_checked  = 0;
    int n_hit      = 0;
    int n_near     = 0;
    int n_victim   = 0;
    int n_literal  = 0;
    int n_fixed    = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [3:0] hash_line(input t_word w);
        t_word s;
        s = (w >> 16) + (w >> 12) + {30'd0, w[1:0]};
        return s[3:0] & 4'(NUM_LINES - 1);
    endfunction

    task automatic load_seed();
        t_word      w;
        logic [3:0] h;
        foreach (cache_ways[i]) cache_ways[i] = '0;
        vict0 = '0;
        vict1 = '0;
        for (int i = 0; i < SEED_COUNT; i++) begin
            w = SEED_WORDS[i];
            h = hash_line(w);
            if (cache_ways[h][3] != '0) begin
                vict1 = vict0;
                vict0 = cache_ways[h][3];
            end
            cache_ways[h] = {cache_ways[h][2:0], w};
        end
    endtask

    task automatic code_word(input t_word w, input logic rst, output t_code_out r);
        logic [3:0] h;
        t_word      near_key;
        int         hit_way;
        int         near_way;
        r = '0;
        if (rst) load_seed();
        if (w == '0) begin
            r.symbol = SYM_BLANK;
        end else if (w == WORD_FALSE) begin
            r.symbol = SYM_OFF;
        end else if (w == WORD_NIL) begin
            r.symbol = SYM_NIL;
        end else begin
            h = hash_line(w);
            near_key = w & NEAR_MASK;
            hit_way = -1;
            for (int k = WAYS - 1; k >= 0; k--) begin
                if (cache_ways[h][k] == w) hit_way = k;
            end
            if (hit_way >= 0) begin
                r.symbol = HIT_BASE + 8'(int'(h) * 4 + hit_way);
                for (int k = hit_way; k > 0; k--) cache_ways[h][k] = cache_ways[h][k-1];
                cache_ways[h][0] = w;
            end else if (w == vict0) begin
                r.symbol = SYM_VICTIM0;
                vict0 = cache_ways[h][3];
                cache_ways[h] = {cache_ways[h][2:0], w};
            end else begin
                near_way = -1;
                for (int k = WAYS - 1; k >= 0; k--) begin
                    if ((cache_ways[h][k] & NEAR_MASK) == near_key) near_way = k;
                end
                if (w == vict1) begin
                    r.symbol = SYM_VICTIM1;
                end else if (near_way >= 0) begin
                    r.symbol = SYM_NEAR_BASE + 8'(int'(h) * 4 + near_way);
                    r.short_count = 2'd1;
                    r.short_first = w[10:3];
                end else if (near_key == (vict0 & NEAR_MASK)) begin
                    r.symbol = SYM_NEAR_V0;
                    r.short_count = 2'd1;
                    r.short_first = w[10:3];
                end else if (near_key == (vict1 & NEAR_MASK)) begin
                    r.symbol = SYM_NEAR_V1;
                    r.short_count = 2'd1;
                    r.short_first = w[10:3];
                end else if (w <= BYTE_HIGH || w >= BYTE_LOW) begin
                    r.symbol = SYM_NEW8;
                    r.short_count = 2'd1;
                    r.short_first = w[7:0];
                end else if ((w & ~PAIR_MASK) == PAIR_TAG) begin
                    r.symbol = SYM_NEW4X2;
                    r.short_count = 2'd1;
                    r.short_first = {w[19:16], w[6:3]};
                end else if (w <= HALF_HIGH) begin
                    r.symbol = SYM_NEW16;
                    r.short_count = 2'd2;
                    r.short_first = w[15:8];
                    r.short_second = w[7:0];
                end else begin
                    r.symbol = SYM_NEW32;
                    r.has_long = 1'b1;
                    r.long_word = w;
                end
                vict1 = vict0;
                vict0 = cache_ways[h][3];
                cache_ways[h] = {cache_ways[h][2:0], w};
            end
        end
        if (r.symbol >= HIT_BASE) n_hit++;
        else if (r.symbol >= SYM_NEAR_BASE || r.symbol == SYM_NEAR_V0 || r.symbol == SYM_NEAR_V1)
            n_near++;
        else if (r.symbol == SYM_VICTIM0 || r.symbol == SYM_VICTIM1) n_victim++;
        else if (r.symbol >= SYM_NEW32) n_literal++;
        else n_fixed++;
    endtask

    // one input transaction: optional idle gap, then hold valid until accepted
    task automatic send_word(input t_word w, input logic rst, input logic typed,
                             input logic [7:0] typed_sym);
        t_code_out predicted;
        t_pending  entry;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_ch.valid     <= 1'b1;
        word_ch.data_word <= w;
        word_ch.restart   <= rst;
        @(posedge i_clk);
        while (!word_ch.ready) @(posedge i_clk);
        code_word(w, rst, predicted);
        if (typed) begin
            predicted = '0;
            predicted.symbol = typed_sym;
        end
        entry.word = w;
        entry.code = predicted;
        pending_codes.push_back(entry);
        n_words++;
        if (rst) n_restarts++;
        if (w != '0 && w != WORD_FALSE && w != WORD_NIL) begin
            recent_words.push_front(w);
            if (recent_words.size() > HISTORY_DEPTH) void'(recent_words.pop_back());
        end
    endtask

    function automatic t_word from_history(input int lo, input int hi);
        int n;
        n = recent_words.size();
        if (n <= lo) return $urandom;
        return recent_words[$urandom_range(lo, (hi < n ? hi : n) - 1)];
    endfunction

    task automatic pick_word(output t_word w, output logic rst);
        int kind;
        kind = $urandom_range(99);
        rst = ($urandom_range(99) < 3);
        if (kind < 30) begin
            w = from_history(0, 8);
        end else if (kind < 40) begin
            w = from_history(8, HISTORY_DEPTH);
        end else if (kind < 48) begin
            w = vict0;
        end else if (kind < 54) begin
            w = vict1;
        end else if (kind < 64) begin
            case ($urandom_range(2))
                0: w = vict0;
                1: w = vict1;
                default: w = from_history(0, 16);
            endcase
            w = w ^ (t_word'($urandom_range(1, 255)) << 3);
        end else if (kind < 70) begin
            case ($urandom_range(2))
                0: w = '0;
                1: w = WORD_FALSE;
                default: w = WORD_NIL;
            endcase
        end else if (kind < 80) begin
            case ($urandom_range(2))
                0: w = t_word'($urandom_range(127));
                1: w = BYTE_LOW | t_word'($urandom_range(127));
                default: w = t_word'($urandom_range(16'hFFFF));
            endcase
        end else if (kind < 85) begin
            w = PAIR_TAG | (t_word'($urandom_range(15)) << 16)
                | (t_word'($urandom_range(15)) << 3);
        end else begin
            w = $urandom;
        end
    endtask

    task automatic check_field(input string name, input t_word w, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: word %h %s expected %h actual %h", $time, w, name, want, got);
        end
    endtask

    // output side: random stall, compare each accepted transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_pending head;
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (pending_codes.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result expected none actual symbol %h",
                         $time, code_ch.symbol);
            end else begin
                head = pending_codes.pop_front();
                n_checked++;
                check_field("symbol", head.word, 32'(head.code.symbol),
                            32'(code_ch.symbol));
                check_field("short_count", head.word, 32'(head.code.short_count),
                            32'(code_ch.short_count));
                check_field("short_first", head.word, 32'(head.code.short_first),
                            32'(code_ch.short_first));
                check_field("short_second", head.word, 32'(head.code.short_second),
                            32'(code_ch.short_second));
                check_field("has_long", head.word, 32'(head.code.has_long),
                            32'(code_ch.has_long));
                check_field("long_word", head.word, head.code.long_word, code_ch.long_word);
            end
        end
        code_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (word_ch.valid && word_ch.ready) || (code_ch.valid && code_ch.ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_codes.size());
        $display("word_cache_compressor_unit_tb: done, errors");
        $finish;
    end

    initial begin
        t_word w;
        logic  rst;
        i_rst_n           = 1'b0;
        word_ch.valid     = 1'b0;
        word_ch.data_word = '0;
        word_ch.restart   = 1'b0;
        load_seed();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_word(DIRECTED[i].word, DIRECTED[i].restart, DIRECTED[i].typed,
                      DIRECTED[i].symbol);

        for (int phase = 0; phase < 4; phase++) begin
            // drain completely before the idling pattern changes
            word_ch.valid <= 1'b0;
            do @(posedge i_clk); while (pending_codes.size() != 0);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int i = 0; i < PHASE_WORDS; i++) begin
                pick_word(w, rst);
                send_word(w, rst, 1'b0, SYM_BLANK);
            end
        end

        word_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_codes.size() != 0);
        repeat (4) @(posedge i_clk);

        $display("sent %0d words (%0d with restart), checked %0d results", n_words, n_restarts,
                 n_checked);
        $display("kinds: %0d hits, %0d near, %0d victim, %0d literal, %0d fixed words",
                 n_hit, n_near, n_victim, n_literal, n_fixed);
        if (n_errors == 0) begin
            $display("word_cache_compressor_unit_tb: done, clean");
        end else begin
            $display("word_cache_compressor_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
